// ===== rtl/ils_pkg.sv =====
// Package for the indexed list store: request/response types, codes and cell commands.
package ils_pkg;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_INSERT    = 3'd1,
    OP_OVERWRITE = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_SEARCH    = 3'd4,
    OP_SORT      = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SORT,
    CELL_PROBE
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_RUN
  } fsm_e;

  // Broadcast command from the sequencer to every cell.
  typedef struct packed {
    cell_op_e op;
    logic     search;  // probe matches on value instead of on position
    logic     parity;  // which pairs compare-swap in this sort step
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         position;
    logic signed [31:0] operand_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [5:0]         found_position;
    logic [1:0]         status;
    logic [6:0]         entry_count;
  } out_rsp_t;

endpackage

// ===== rtl/ils_cell.sv =====
// One list cell: holds a single entry and one stage of the probe chain.
module ils_cell #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX       = 0,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int CW         = (CNT_W > 7) ? CNT_W : 7,
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ils_pkg::cell_cmd_t     cmd_i,
  input  logic [CW-1:0]          pos_i,
  input  logic [CW-1:0]          count_i,
  input  logic [VALUE_WIDTH-1:0] wr_val_i,
  input  logic [VALUE_WIDTH-1:0] left_val_i,
  input  logic [VALUE_WIDTH-1:0] right_val_i,
  output logic [VALUE_WIDTH-1:0] val_o,
  input  logic                   left_hit_i,
  input  logic [VALUE_WIDTH-1:0] left_pval_i,
  input  logic [IDX_W-1:0]       left_pidx_i,
  output logic                   hit_o,
  output logic [VALUE_WIDTH-1:0] pval_o,
  output logic [IDX_W-1:0]       pidx_o
);
  import ils_pkg::*;

  localparam logic [CW-1:0]    ME       = CW'(INDEX);
  localparam logic [CW-1:0]    ME_NEXT  = CW'(INDEX + 1);
  localparam logic [IDX_W-1:0] ME_IDX   = IDX_W'(INDEX);
  localparam bit               HAS_LEFT = (INDEX > 0);

  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   hit_q, hit_d;
  logic [VALUE_WIDTH-1:0] pval_q, pval_d;
  logic [IDX_W-1:0]       pidx_q, pidx_d;
  logic                   gt_right, gt_left, match;

  assign gt_right = $signed(val_q) > $signed(right_val_i);
  assign gt_left  = $signed(left_val_i) > $signed(val_q);

  always_comb begin
    val_d = val_q;
    unique case (cmd_i.op)
      CELL_WRITE: begin
        if (ME == pos_i) val_d = wr_val_i;
      end
      CELL_INSERT: begin
        if (ME == pos_i) begin
          val_d = wr_val_i;
        end else if (HAS_LEFT && ME > pos_i && ME <= count_i) begin
          val_d = left_val_i;
        end
      end
      CELL_REMOVE: begin
        if (ME >= pos_i && ME_NEXT < count_i) val_d = right_val_i;
      end
      CELL_SORT: begin
        // Lower member of an active pair takes the smaller value, upper the larger.
        if (ME[0] == cmd_i.parity) begin
          if (ME_NEXT < count_i && gt_right) val_d = right_val_i;
        end else begin
          if (HAS_LEFT && ME < count_i && gt_left) val_d = left_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  // Probe chain: an earlier hit passes through, otherwise offer this entry.
  assign match = (ME < count_i) &&
                 (cmd_i.search ? (val_q == wr_val_i) : (ME == pos_i));

  always_comb begin
    if (HAS_LEFT && left_hit_i) begin
      hit_d  = 1'b1;
      pval_d = left_pval_i;
      pidx_d = left_pidx_i;
    end else begin
      hit_d  = match;
      pval_d = val_q;
      pidx_d = ME_IDX;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pval_q <= pval_d;
    pidx_q <= pidx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign val_o  = val_q;
  assign hit_o  = hit_q;
  assign pval_o = pval_q;
  assign pidx_o = pidx_q;

endmodule

// ===== rtl/ils_ctrl.sv =====
// Sequencer for the list store: handshakes, capacity, entry count, cell commands.
module ils_ctrl #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32,
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int CW         = (CNT_W > 7) ? CNT_W : 7,
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [6:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  input  ils_pkg::in_req_t       in_req_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output ils_pkg::out_rsp_t      out_rsp_o,
  input  logic                   out_stall_i,
  output ils_pkg::cell_cmd_t     cmd_o,
  output logic [CW-1:0]          pos_o,
  output logic [CW-1:0]          count_o,
  output logic [VALUE_WIDTH-1:0] wr_val_o,
  input  logic                   probe_hit_i,
  input  logic [VALUE_WIDTH-1:0] probe_val_i,
  input  logic [IDX_W-1:0]       probe_idx_i
);
  import ils_pkg::*;

  localparam logic [CNT_W-1:0] LONG_STEPS  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] SHORT_STEPS = CNT_W'(1);

  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [6:0]       cap_q;
  in_req_t          req_q;
  status_e          status_q, status_new;
  out_rsp_t         rsp_q, rsp_new;
  logic             out_valid_q, out_valid_d;
  logic             accept, load_rsp, slot_free, last_step;
  logic [CNT_W-1:0] limit;
  logic [CW-1:0]    in_pos_w, cnt_w, cap_w, eff_cap;

  assign cnt_w    = CW'(count_q);
  assign in_pos_w = CW'(in_req_i.position);
  assign cap_w    = CW'(cap_q);
  assign eff_cap  = (cap_w > CW'(DEPTH)) ? CW'(DEPTH) : cap_w;

  // Check the request against the list as it stands when taken.
  always_comb begin
    status_new = ST_OK;
    unique case (in_req_i.opcode)
      OP_READ, OP_OVERWRITE, OP_REMOVE: begin
        if (!(in_pos_w < cnt_w)) status_new = ST_BAD_INDEX;
      end
      OP_INSERT: begin
        if (cnt_w >= eff_cap)      status_new = ST_OVERFLOW;
        else if (in_pos_w > cnt_w) status_new = ST_BAD_INDEX;
      end
      default: status_new = ST_OK;
    endcase
  end

  always_comb begin
    unique case (req_q.opcode)
      OP_READ, OP_SEARCH, OP_SORT: limit = LONG_STEPS;
      default:                     limit = SHORT_STEPS;
    endcase
  end

  assign accept    = (state_q == FSM_IDLE) && in_valid_i;
  assign last_step = (step_q == limit);
  assign slot_free = !out_valid_q || !out_stall_i;

  // Cell command and sequencing.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    load_rsp    = 1'b0;
    cmd_o.op    = CELL_HOLD;
    cmd_o.search = (req_q.opcode == OP_SEARCH);
    cmd_o.parity = step_q[0];
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_RUN;
          step_d  = '0;
        end
      end
      FSM_RUN: begin
        if (!last_step) begin
          step_d = step_q + CNT_W'(1);
          unique case (req_q.opcode)
            OP_READ, OP_SEARCH: cmd_o.op = CELL_PROBE;
            OP_SORT:            cmd_o.op = CELL_SORT;
            OP_INSERT: begin
              if (status_q == ST_OK) begin
                cmd_o.op = CELL_INSERT;
                count_d  = count_q + CNT_W'(1);
              end
            end
            OP_OVERWRITE: begin
              if (status_q == ST_OK) cmd_o.op = CELL_WRITE;
            end
            OP_REMOVE: begin
              if (status_q == ST_OK) begin
                cmd_o.op = CELL_REMOVE;
                count_d  = count_q - CNT_W'(1);
              end
            end
            default: cmd_o.op = CELL_HOLD;
          endcase
        end else if (slot_free) begin
          load_rsp = 1'b1;
          state_d  = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    rsp_new.read_value     = '0;
    rsp_new.found_position = '0;
    rsp_new.status         = status_q;
    rsp_new.entry_count    = 7'(count_q);
    if (req_q.opcode == OP_READ && status_q == ST_OK) begin
      rsp_new.read_value = 32'(probe_val_i);
    end
    if (req_q.opcode == OP_SEARCH) begin
      if (probe_hit_i) begin
        rsp_new.status         = ST_OK;
        rsp_new.found_position = 6'(probe_idx_i);
      end else begin
        rsp_new.status = ST_NOT_FOUND;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_rsp)                        out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      cap_q       <= 7'd64;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= in_req_i;
      status_q <= status_new;
    end
    if (load_rsp) rsp_q <= rsp_new;
  end

  assign in_stall_o  = (state_q != FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign pos_o       = CW'(req_q.position);
  assign count_o     = CW'(count_q);
  assign wr_val_o    = VALUE_WIDTH'(req_q.operand_value);

endmodule

// ===== rtl/indexed_list_store.sv =====
// Top level of the indexed list store: sequencer plus a row of list cells.
//
// An ordered list of up to DEPTH signed entries, one per cell, limited to the
// written capacity (clipped to DEPTH). One request is in flight at a time:
// the input stalls from acceptance until the response is loaded into the
// output register, so a new request can be taken while the previous response
// still waits to be taken. Insert, overwrite and remove shift or write all
// cells in parallel in one step. Read and search run a registered probe
// chain through the cells and sort runs DEPTH odd/even compare-swap steps
// between neighbors; each response is loaded into the output register after
// the last step. Responses wait in the output register while the downstream
// stalls. Entries are undefined until written; no clear pass runs after
// reset, and only indices below the entry count are ever read.
module indexed_list_store #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  ils_pkg::in_req_t  in_req_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output ils_pkg::out_rsp_t out_rsp_o,
  input  logic              out_stall_i
);
  import ils_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cell_cmd_t              cmd;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          count;
  logic [VALUE_WIDTH-1:0] wr_val;

  // Neighbor links along the row.
  logic [VALUE_WIDTH-1:0] val   [DEPTH];
  logic                   hit   [DEPTH];
  logic [VALUE_WIDTH-1:0] pval  [DEPTH];
  logic [IDX_W-1:0]       pidx  [DEPTH];

  ils_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .pos_o       (pos),
    .count_o     (count),
    .wr_val_o    (wr_val),
    .probe_hit_i (hit[DEPTH-1]),
    .probe_val_i (pval[DEPTH-1]),
    .probe_idx_i (pidx[DEPTH-1])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_val, right_val, left_pval;
    logic                   left_hit;
    logic [IDX_W-1:0]       left_pidx;

    // Tie off the row ends; the cells never take data across them.
    if (i == 0) begin : g_first
      assign left_val  = '0;
      assign left_hit  = 1'b0;
      assign left_pval = '0;
      assign left_pidx = '0;
    end else begin : g_inner_left
      assign left_val  = val[i-1];
      assign left_hit  = hit[i-1];
      assign left_pval = pval[i-1];
      assign left_pidx = pidx[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner_right
      assign right_val = val[i+1];
    end

    ils_cell #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .pos_i       (pos),
      .count_i     (count),
      .wr_val_i    (wr_val),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .val_o       (val[i]),
      .left_hit_i  (left_hit),
      .left_pval_i (left_pval),
      .left_pidx_i (left_pidx),
      .hit_o       (hit[i]),
      .pval_o      (pval[i]),
      .pidx_o      (pidx[i])
    );
  end

endmodule
